[src/plt_pkg.sv]
// shared types, register codes and helpers for the plucker line transform
`default_nettype none

package plt_pkg;

    localparam int COORD_W    = 32;
    localparam int ROT_W      = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // product and sum widths inside the datapath
    localparam int PROD_W     = COORD_W + ROT_W;        // t*r, r*m, r*d
    localparam int DIFF_W     = PROD_W + 1;             // t*r - t*r
    localparam int DOT_W      = PROD_W + 2;             // sum of three products
    localparam int FRAC_R     = 14;                     // Q2.14 fraction bits
    localparam int FRAC_T     = 16;                     // Q16.16 fraction bits
    localparam int ROT_SUM_W  = DOT_W - FRAC_R;         // R m, R d after scaling
    localparam int ED_PROD_W  = 2 * COORD_W;            // e*d
    localparam int ED_TERM_W  = ED_PROD_W - FRAC_T;     // e*d after scaling
    localparam int ED_SUM_W   = ED_TERM_W + 2;
    localparam int SAT_IN_W   = 52;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ROT_W-1:0]   rot_ent_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW_0 = 3'd0,
        REG_ROT_ROW_1 = 3'd1,
        REG_ROT_ROW_2 = 3'd2,
        REG_TRANS_X   = 3'd3,
        REG_TRANS_Y   = 3'd4,
        REG_TRANS_Z   = 3'd5
    } cfg_reg_t;

    // rigid pose: rot[i][j] is row i, column j
    typedef struct packed {
        logic [2:0][2:0][ROT_W-1:0] rot;
        logic [2:0][COORD_W-1:0]    trans;
    } pose_t;

    // identity rotation, zero translation
    localparam logic [9*ROT_W-1:0] ROT_IDENT =
        144'h4000_0000_0000_0000_4000_0000_0000_0000_4000;
    localparam pose_t POSE_RESET = '{rot: ROT_IDENT, trans: '0};

    // clamp a wide signed value to signed 32 bits
    function automatic coord_t sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] max_v;
        logic signed [SAT_IN_W-1:0] min_v;
        max_v = SAT_IN_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
        min_v = SAT_IN_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
        if (v > max_v)
        begin
            sat32 = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < min_v)
        begin
            sat32 = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/plt_if.sv]
// valid/ready channels for input lines and transformed lines
`default_nettype none

interface plt_line_if
    import plt_pkg::*;
    ;
    logic   valid;
    logic   ready;
    coord_t moment_x;
    coord_t moment_y;
    coord_t moment_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;

    modport source (output valid, moment_x, moment_y, moment_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, moment_x, moment_y, moment_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface plt_result_if
    import plt_pkg::*;
    ;
    logic   valid;
    logic   ready;
    coord_t new_moment_x;
    coord_t new_moment_y;
    coord_t new_moment_z;
    coord_t new_dir_x;
    coord_t new_dir_y;
    coord_t new_dir_z;

    modport source (output valid, new_moment_x, new_moment_y, new_moment_z,
                    new_dir_x, new_dir_y, new_dir_z,
                    input ready);
    modport sink   (input valid, new_moment_x, new_moment_y, new_moment_z,
                    new_dir_x, new_dir_y, new_dir_z,
                    output ready);
endinterface

`default_nettype wire

[src/plucker_line_rigid_transform_top.sv]
// rigid pose transform of pluecker lines, four-stage multiply pipeline
// a request is registered in stages a, b, c and o in turn before its result appears on line_rsp
// throughput: one line per cycle unless line_rsp stalls; each stage is one bank of multipliers or one adder level
// stalls back up stage by stage, bubbles are squeezed out, nothing is dropped
// reset: all stage valid bits clear, pose returns to identity rotation, zero translation
`default_nettype none

module plucker_line_rigid_transform_top
    import plt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    plt_line_if.sink                   line_req,
    plt_result_if.source               line_rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    pose_t pose;

    plt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pose      (pose)
    );

    // stage enables, each stage moves when empty or when the next one moves
    logic a_v_reg, b_v_reg, c_v_reg, o_v_reg;
    logic a_en, b_en, c_en, o_en;

    assign o_en = !o_v_reg || line_rsp.ready;
    assign c_en = !c_v_reg || o_en;
    assign b_en = !b_v_reg || c_en;
    assign a_en = !a_v_reg || b_en;

    assign line_req.ready = a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_v_reg <= line_req.valid;
            end
            if (b_en)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_en)
            begin
                c_v_reg <= b_v_reg;
            end
            if (o_en)
            begin
                o_v_reg <= c_v_reg;
            end
        end
    end

    // input vectors
    coord_t m_in [3];
    coord_t d_in [3];

    assign m_in[0] = line_req.moment_x;
    assign m_in[1] = line_req.moment_y;
    assign m_in[2] = line_req.moment_z;
    assign d_in[0] = line_req.dir_x;
    assign d_in[1] = line_req.dir_y;
    assign d_in[2] = line_req.dir_z;

    // stage a: all t*r, r*m and r*d products
    logic signed [PROD_W-1:0] tr_hi_next [3][3];
    logic signed [PROD_W-1:0] tr_lo_next [3][3];
    logic signed [PROD_W-1:0] rm_p_next  [3][3];
    logic signed [PROD_W-1:0] rd_p_next  [3][3];
    logic signed [PROD_W-1:0] tr_hi_reg  [3][3];
    logic signed [PROD_W-1:0] tr_lo_reg  [3][3];
    logic signed [PROD_W-1:0] rm_p_reg   [3][3];
    logic signed [PROD_W-1:0] rd_p_reg   [3][3];
    coord_t                   d_a_reg    [3];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_row
        localparam int I1 = (gi + 1) % 3;
        localparam int I2 = (gi + 2) % 3;
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_col
            // row gi of [t]x R
            assign tr_hi_next[gi][gj] = $signed(pose.trans[I1]) * $signed(pose.rot[I2][gj]);
            assign tr_lo_next[gi][gj] = $signed(pose.trans[I2]) * $signed(pose.rot[I1][gj]);
            assign rm_p_next[gi][gj]  = $signed(pose.rot[gi][gj]) * m_in[gj];
            assign rd_p_next[gi][gj]  = $signed(pose.rot[gi][gj]) * d_in[gj];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    tr_hi_reg[i][j] <= tr_hi_next[i][j];
                    tr_lo_reg[i][j] <= tr_lo_next[i][j];
                    rm_p_reg[i][j]  <= rm_p_next[i][j];
                    rd_p_reg[i][j]  <= rd_p_next[i][j];
                end
                d_a_reg[i] <= d_in[i];
            end
        end
    end

    // stage b: E entries, scaled R m and R d
    coord_t                      e_next  [3][3];
    logic signed [ROT_SUM_W-1:0] rm_next [3];
    logic signed [ROT_SUM_W-1:0] rd_next [3];
    coord_t                      e_reg   [3][3];
    logic signed [ROT_SUM_W-1:0] rm_b_reg [3];
    logic signed [ROT_SUM_W-1:0] rd_b_reg [3];
    coord_t                      d_b_reg [3];

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] diff_sh;
        logic signed [DOT_W-1:0]  rm_sum;
        logic signed [DOT_W-1:0]  rd_sum;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                diff        = DIFF_W'(tr_hi_reg[i][j]) - DIFF_W'(tr_lo_reg[i][j]);
                diff_sh     = diff >>> FRAC_R;
                e_next[i][j] = sat32(SAT_IN_W'(diff_sh));
            end
            rm_sum = DOT_W'(rm_p_reg[i][0]) + DOT_W'(rm_p_reg[i][1])
                   + DOT_W'(rm_p_reg[i][2]);
            rd_sum = DOT_W'(rd_p_reg[i][0]) + DOT_W'(rd_p_reg[i][1])
                   + DOT_W'(rd_p_reg[i][2]);
            rm_next[i] = $signed(rm_sum[DOT_W-1:FRAC_R]);
            rd_next[i] = $signed(rd_sum[DOT_W-1:FRAC_R]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    e_reg[i][j] <= e_next[i][j];
                end
                rm_b_reg[i] <= rm_next[i];
                rd_b_reg[i] <= rd_next[i];
                d_b_reg[i]  <= d_a_reg[i];
            end
        end
    end

    // stage c: E d products
    logic signed [ED_PROD_W-1:0] ed_p_next [3][3];
    logic signed [ED_PROD_W-1:0] ed_p_reg  [3][3];
    logic signed [ROT_SUM_W-1:0] rm_c_reg  [3];
    logic signed [ROT_SUM_W-1:0] rd_c_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ed_p_next[i][j] = e_reg[i][j] * d_b_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ed_p_reg[i][j] <= ed_p_next[i][j];
                end
                rm_c_reg[i] <= rm_b_reg[i];
                rd_c_reg[i] <= rd_b_reg[i];
            end
        end
    end

    // stage o: scale each E d term, add R m, saturate
    coord_t new_m_next [3];
    coord_t new_d_next [3];
    coord_t new_m_reg  [3];
    coord_t new_d_reg  [3];

    always_comb
    begin
        logic signed [ED_SUM_W-1:0] ed_sum;
        logic signed [SAT_IN_W-1:0] m_sum;
        for (int i = 0; i < 3; i++)
        begin
            ed_sum = ED_SUM_W'($signed(ed_p_reg[i][0][ED_PROD_W-1:FRAC_T]))
                   + ED_SUM_W'($signed(ed_p_reg[i][1][ED_PROD_W-1:FRAC_T]))
                   + ED_SUM_W'($signed(ed_p_reg[i][2][ED_PROD_W-1:FRAC_T]));
            m_sum  = SAT_IN_W'(rm_c_reg[i]) + SAT_IN_W'(ed_sum);
            new_m_next[i] = sat32(m_sum);
            new_d_next[i] = sat32(SAT_IN_W'(rd_c_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                new_m_reg[i] <= new_m_next[i];
                new_d_reg[i] <= new_d_next[i];
            end
        end
    end

    // result channel
    assign line_rsp.valid        = o_v_reg;
    assign line_rsp.new_moment_x = new_m_reg[0];
    assign line_rsp.new_moment_y = new_m_reg[1];
    assign line_rsp.new_moment_z = new_m_reg[2];
    assign line_rsp.new_dir_x    = new_d_reg[0];
    assign line_rsp.new_dir_y    = new_d_reg[1];
    assign line_rsp.new_dir_z    = new_d_reg[2];

endmodule

`default_nettype wire

[src/plt_cfg.sv]
// pose configuration registers with write decode
`default_nettype none

module plt_cfg
    import plt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output pose_t                      pose
);

    pose_t pose_reg;
    pose_t pose_next;

    // write decode, unknown indexes are dropped
    always_comb
    begin
        pose_next = pose_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT_ROW_0:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        pose_next.rot[0][j] = cfg_wdata[ROT_W*j +: ROT_W];
                    end
                end
                REG_ROT_ROW_1:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        pose_next.rot[1][j] = cfg_wdata[ROT_W*j +: ROT_W];
                    end
                end
                REG_ROT_ROW_2:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        pose_next.rot[2][j] = cfg_wdata[ROT_W*j +: ROT_W];
                    end
                end
                REG_TRANS_X: pose_next.trans[0] = cfg_wdata[COORD_W-1:0];
                REG_TRANS_Y: pose_next.trans[1] = cfg_wdata[COORD_W-1:0];
                REG_TRANS_Z: pose_next.trans[2] = cfg_wdata[COORD_W-1:0];
                default:     pose_next = pose_reg;
            endcase
        end
    end

    // pose storage, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg <= POSE_RESET;
        end
        else
        begin
            pose_reg <= pose_next;
        end
    end

    assign pose = pose_reg;

endmodule

`default_nettype wire
